### rtl/dssl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssl_pkg
// Shared constants, register codes and controller/datapath link types for
// the deflection speed LED sweep.
// ----------------------------------------------------------------------------
package dssl_pkg;

   localparam int LED_COUNT  = 5;
   localparam int FULL_SCALE = 512;

   localparam int DEFL_W     = 10;
   localparam int TIME_W     = 32;
   localparam int DZ_W       = 9;
   localparam int DLY_W      = 16;
   localparam int LED_W      = 5;
   localparam int POS_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int IDX_W  = $clog2(LED_COUNT);
   localparam int FS_W   = $clog2(FULL_SCALE + 1);
   localparam int DEN_W  = (FS_W > DEFL_W) ? FS_W : DEFL_W;
   localparam int PROD_W = DEN_W + DLY_W;
   localparam int CNT_W  = $clog2(PROD_W);

   localparam logic [DZ_W-1:0]  DEAD_ZONE_RST = DZ_W'(50);
   localparam logic [DLY_W-1:0] DELAY_MIN_RST = DLY_W'(30);
   localparam logic [DLY_W-1:0] DELAY_MAX_RST = DLY_W'(200);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEAD_ZONE = 2'd0,
      CSR_DELAY_MIN = 2'd1,
      CSR_DELAY_MAX = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic req_ready;
      logic load_in;
      logic load_div;
      logic div_step;
      logic commit;
   } dssl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_busy;
   } dssl_sts_type;

endpackage
`default_nettype wire

### rtl/dssl_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssl_req_if
// Input item channel: deflection sample and millisecond time stamp.
// ----------------------------------------------------------------------------
interface dssl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dssl_pkg::DEFL_W-1:0]    deflection;
   logic        [dssl_pkg::TIME_W-1:0]    now_ms;

   modport source (output valid, output deflection, output now_ms, input ready);
   modport sink   (input valid, input deflection, input now_ms, output ready);
endinterface
`default_nettype wire

### rtl/dssl_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssl_rsp_if
// Result item channel: LED pattern, sweep position and idle flag.
// ----------------------------------------------------------------------------
interface dssl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dssl_pkg::LED_W-1:0]    led_pattern;
   logic [dssl_pkg::POS_W-1:0]    position;
   logic                          idle;

   modport source (output valid, output led_pattern, output position, output idle,
                   input ready);
   modport sink   (input valid, input led_pattern, input position, input idle,
                   output ready);
endinterface
`default_nettype wire

### rtl/dssl_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssl_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dssl_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dssl_pkg::CSR_IDX_W-1:0]    index;
   logic [dssl_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/dssl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssl_ctrl
// Sequencer: accepts an item, runs the multiply and the bit-serial divide
// when a step check is needed, then commits the result.
// ----------------------------------------------------------------------------
module dssl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  dssl_pkg::dssl_sts_type  sts,
   output dssl_pkg::dssl_cmd_type  cmd
);
   import dssl_pkg::*;

   typedef enum logic [2:0] {
      S_WAIT,
      S_EVAL,
      S_LOAD,
      S_DIV,
      S_PUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_WAIT: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = sts.need_div ? S_LOAD : S_PUT;
         end
         S_LOAD: begin
            cmd.load_div = 1'b1;
            cnt_in       = CNT_W'(PROD_W - 1);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_PUT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_PUT: begin
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_WAIT;
            end
         end
         default: begin
            state_in = S_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### rtl/dssl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssl_dp
// Datapath: config registers, sweep state, excess-times-span multiply,
// restoring divider (one quotient bit per cycle) and the output register.
// ----------------------------------------------------------------------------
module dssl_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dssl_pkg::dssl_cmd_type               cmd,
   output dssl_pkg::dssl_sts_type               sts,
   input  logic signed [dssl_pkg::DEFL_W-1:0]   req_deflection,
   input  logic        [dssl_pkg::TIME_W-1:0]   req_now_ms,
   input  logic                                 csr_valid,
   input  logic [dssl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dssl_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [dssl_pkg::LED_W-1:0]           rsp_led_pattern,
   output logic [dssl_pkg::POS_W-1:0]           rsp_position,
   output logic                                 rsp_idle
);
   import dssl_pkg::*;

   // config
   logic [DZ_W-1:0]   dz_ff, dz_in;
   logic [DLY_W-1:0]  dmin_ff, dmin_in;
   logic [DLY_W-1:0]  dmax_ff, dmax_in;

   // sweep state
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              idle_ff, idle_in;
   logic [TIME_W-1:0] last_ff, last_in;

   // latched item
   logic [DEFL_W-1:0] mag_ff;
   logic              pos_dir_ff;
   logic [TIME_W-1:0] now_ff;

   // divider
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LED_W-1:0]  rsp_led_ff, rsp_led_in;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_idle_ff;

   logic [DEFL_W-1:0] raw;
   logic [DEFL_W-1:0] mag_in;
   logic [DEN_W-1:0]  mag_w, dz_w, denom, excess, excess_c;
   logic              quiet, fs_le_dz;
   logic [DLY_W-1:0]  span, delay;
   logic [DEN_W:0]    shifted, diff;
   logic [TIME_W-1:0] elapsed;
   logic              step_due;

   assign raw    = req_deflection;
   assign mag_in = raw[DEFL_W-1] ? (~raw + 1'b1) : raw;

   assign mag_w    = DEN_W'(mag_ff);
   assign dz_w     = DEN_W'(dz_ff);
   assign quiet    = (mag_w <= dz_w);
   assign fs_le_dz = (DEN_W'(FULL_SCALE) <= dz_w);
   assign denom    = DEN_W'(FULL_SCALE) - dz_w;
   assign excess   = mag_w - dz_w;
   assign excess_c = (excess > denom) ? denom : excess;
   assign span     = (dmax_ff > dmin_ff) ? (dmax_ff - dmin_ff) : '0;

   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign diff    = shifted - {1'b0, denom};

   assign delay    = fs_le_dz ? dmin_ff : (dmax_ff - quo_ff[DLY_W-1:0]);
   assign elapsed  = now_ff - last_ff;
   assign step_due = (elapsed >= TIME_W'(delay));

   assign sts.need_div = !quiet && !idle_ff;
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      dz_in   = dz_ff;
      dmin_in = dmin_ff;
      dmax_in = dmax_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEAD_ZONE: dz_in   = csr_data[DZ_W-1:0];
            CSR_DELAY_MIN: dmin_in = csr_data[DLY_W-1:0];
            CSR_DELAY_MAX: dmax_in = csr_data[DLY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.load_div) begin
         rem_in = '0;
         quo_in = PROD_W'(excess_c) * PROD_W'(span);
      end else if (cmd.div_step) begin
         rem_in = diff[DEN_W] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], ~diff[DEN_W]};
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      idle_in = idle_ff;
      last_in = last_ff;
      if (quiet) begin
         idle_in = 1'b1;
      end else if (idle_ff) begin
         idle_in = 1'b0;
         last_in = now_ff;
      end else if (step_due) begin
         last_in = now_ff;
         if (pos_dir_ff) begin
            idx_in = (idx_ff == IDX_W'(LED_COUNT - 1)) ? '0 : idx_ff + 1'b1;
         end else begin
            idx_in = (idx_ff == '0) ? IDX_W'(LED_COUNT - 1) : idx_ff - 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LED_W; i++) begin
         rsp_led_in[i] = (i < LED_COUNT) && !idle_in && (idx_in == IDX_W'(i));
      end
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff        <= DEAD_ZONE_RST;
         dmin_ff      <= DELAY_MIN_RST;
         dmax_ff      <= DELAY_MAX_RST;
         idx_ff       <= '0;
         idle_ff      <= 1'b1;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dz_ff        <= dz_in;
         dmin_ff      <= dmin_in;
         dmax_ff      <= dmax_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            idx_ff  <= idx_in;
            idle_ff <= idle_in;
            last_ff <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         mag_ff     <= mag_in;
         pos_dir_ff <= !raw[DEFL_W-1] && (raw != '0);
         now_ff     <= req_now_ms;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.commit) begin
         rsp_led_ff  <= rsp_led_in;
         rsp_pos_ff  <= POS_W'(idx_in);
         rsp_idle_ff <= idle_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_pattern = rsp_led_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_idle        = rsp_idle_ff;

endmodule
`default_nettype wire

### rtl/deflection_speed_led_sweep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deflection_speed_led_sweep
// Walks one lit LED along a row at a speed set by a signed deflection.
// ----------------------------------------------------------------------------
// One result item per input item. An item inside the dead zone or the first
// one after leaving it skips the divide and goes straight to the result;
// any other item passes the restoring divider that forms one quotient bit
// per cycle of excess * span / (FULL_SCALE minus the dead-zone width). One
// item is in work at a time; the output register lets the next item in
// while a result waits to be taken. Register writes are always ready and
// take effect on the next cycle.
// ----------------------------------------------------------------------------
module deflection_speed_led_sweep (
   input  logic       clock,
   input  logic       reset,
   dssl_req_if.sink   req_ch,
   dssl_rsp_if.source rsp_ch,
   dssl_csr_if.sink   csr_ch
);
   import dssl_pkg::*;

   dssl_cmd_type cmd_s;
   dssl_sts_type sts_s;

   assign req_ch.ready = cmd_s.req_ready;
   assign csr_ch.ready = 1'b1;

   dssl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .sts       (sts_s),
      .cmd       (cmd_s)
   );

   dssl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd_s),
      .sts             (sts_s),
      .req_deflection  (req_ch.deflection),
      .req_now_ms      (req_ch.now_ms),
      .csr_valid       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_led_pattern (rsp_ch.led_pattern),
      .rsp_position    (rsp_ch.position),
      .rsp_idle        (rsp_ch.idle)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd_s.commit |-> !sts_s.out_busy)
      else $error("result committed over a pending item");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while previous one in work");

   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.idle) |-> (rsp_ch.led_pattern == '0))
      else $error("LED lit while idle");

   a_single_led: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $onehot0(rsp_ch.led_pattern))
      else $error("more than one LED lit");

endmodule
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deflection speed LED sweep. A scoreboard class
// tracks the sweep position, dead-zone state and step timer for every
// accepted sample and compares each result item field by field. The stimulus
// is a short directed run on the reset settings, followed by phases of
// joystick gestures and random noise under a range of register settings.
// Both sides idle at random, with one phase that runs without gaps.
// ----------------------------------------------------------------------------
module tb;
   import dssl_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 4000;
   localparam int IDLE_PCT      = 32;
   localparam int PHASE_ITEMS   = 185;
   localparam int NUM_SETTINGS  = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [LED_W-1:0] led_pattern;
      logic [POS_W-1:0] position;
      logic             idle;
   } sweep_result_type;

   class sweep_scoreboard;
      logic [DZ_W-1:0]   dz_level  = DEAD_ZONE_RST;
      logic [DLY_W-1:0]  delay_min = DELAY_MIN_RST;
      logic [DLY_W-1:0]  delay_max = DELAY_MAX_RST;
      int                led_idx   = 0;
      bit                dormant   = 1'b1;
      logic [TIME_W-1:0] last_step = '0;
      sweep_result_type  expected_leds[$];
      int                errors  = 0;
      int                samples = 0;
      int                steps   = 0;
      int                exits   = 0;

      function logic [TIME_W-1:0] step_delay(int mag);
         longint denom;
         longint excess;
         longint span;
         if (FULL_SCALE <= dz_level) return TIME_W'(delay_min);
         denom  = FULL_SCALE - longint'(dz_level);
         excess = mag - longint'(dz_level);
         if (excess > denom) excess = denom;
         span = (delay_max > delay_min) ? longint'(delay_max) - longint'(delay_min) : 0;
         return TIME_W'(longint'(delay_max) - excess * span / denom);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_DEAD_ZONE: dz_level  = data[DZ_W-1:0];
            CSR_DELAY_MIN: delay_min = data[DLY_W-1:0];
            CSR_DELAY_MAX: delay_max = data[DLY_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [DEFL_W-1:0] deflection,
                                logic [TIME_W-1:0] now_ms);
         int               signed_defl;
         int               mag;
         sweep_result_type r;
         signed_defl = deflection;
         mag = (signed_defl < 0) ? -signed_defl : signed_defl;
         samples++;
         if (mag <= dz_level) begin
            dormant = 1'b1;
         end else if (dormant) begin
            dormant   = 1'b0;
            last_step = now_ms;
            exits++;
         end else if (TIME_W'(now_ms - last_step) >= step_delay(mag)) begin
            last_step = now_ms;
            steps++;
            if (signed_defl > 0) begin
               led_idx = (led_idx + 1) % LED_COUNT;
            end else begin
               led_idx = (led_idx == 0) ? LED_COUNT - 1 : led_idx - 1;
            end
         end
         r.led_pattern = dormant ? '0 : LED_W'(1 << led_idx);
         r.position    = POS_W'(led_idx);
         r.idle        = dormant;
         expected_leds.push_back(r);
      endfunction

      function void check_result(logic [LED_W-1:0] led_pattern,
                                 logic [POS_W-1:0] position, logic idle);
         sweep_result_type want;
         if (expected_leds.size() == 0) begin
            $error("unexpected item: led_pattern %b position %0d idle %b",
                   led_pattern, position, idle);
            errors++;
            return;
         end
         want = expected_leds.pop_front();
         if (led_pattern !== want.led_pattern) begin
            $error("led_pattern: expected %b, actual %b", want.led_pattern, led_pattern);
            errors++;
         end
         if (position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position);
            errors++;
         end
         if (idle !== want.idle) begin
            $error("idle: expected %b, actual %b", want.idle, idle);
            errors++;
         end
      endfunction

      function int pending();
         return expected_leds.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   dssl_req_if req_ch();
   dssl_rsp_if rsp_ch();
   dssl_csr_if csr_ch();

   deflection_speed_led_sweep dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sweep_scoreboard   board = new();
   bit                calm  = 1'b0;
   int                sent  = 0;
   int                quiet_cycles = 0;
   logic [TIME_W-1:0] tstamp;

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && (calm || $urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_sample(req_ch.deflection, req_ch.now_ms);
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_result(rsp_ch.led_pattern, rsp_ch.position, rsp_ch.idle);
         end
         if (csr_ch.valid && csr_ch.ready) board.write_reg(csr_ch.index, csr_ch.data);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_sample(logic signed [DEFL_W-1:0] defl, logic [TIME_W-1:0] stamp);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.deflection <= defl;
      req_ch.now_ms     <= stamp;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_settings(int dz, int lo, int hi);
      drain_results();
      // upper data bits above the dead-zone field must be dropped
      write_csr(CSR_DEAD_ZONE, {(CSR_DATA_W-DZ_W)'($urandom), DZ_W'(dz)});
      write_csr(CSR_DELAY_MIN, CSR_DATA_W'(lo));
      write_csr(CSR_DELAY_MAX, CSR_DATA_W'(hi));
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int                       dz;
      int                       lo;
      int                       hi;
      int                       mag;
      int                       sgn;
      int                       n;
      int                       phase_end;
      logic [TIME_W-1:0]        dly;
      logic signed [DEFL_W-1:0] defl;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.deflection = '0;
      req_ch.now_ms     = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.data       = '0;
      tstamp            = '0;
      mag               = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: dead zone 50, delays 30..200
      send_sample(0, 0);
      send_sample(511, 10);
      send_sample(511, 40);
      send_sample(511, 41);
      send_sample(50, 50);
      send_sample(51, 60);
      send_sample(51, 260);
      send_sample(-51, 459);
      send_sample(-51, 460);
      send_sample(-512, 700);
      send_sample(-512, 730);
      send_sample(-50, 731);
      send_sample(-1, 732);
      send_sample(511, 32'hFFFF_FFF0);
      send_sample(511, 32'h0000_0010);
      send_sample(-512, 32'h0000_0010);
      send_sample(-511, 32'h0000_0020);
      send_sample(0, 32'h0000_0040);

      for (int p = 0; p <= NUM_SETTINGS; p++) begin
         if (p > 0) begin
            case (p)
               1: begin dz = 0;   lo = 0;     hi = 65535; end
               2: begin dz = 511; lo = 65535; hi = 0;     end
               3: begin dz = 50;  lo = 100;   hi = 100;   end
               4: begin dz = 300; lo = 500;   hi = 20;    end
               5: begin
                  dz = $urandom_range(511);
                  lo = $urandom_range(400);
                  hi = $urandom_range(2000);
               end
               6: begin dz = 0; lo = 65535; hi = 65535; end
               7: begin dz = $urandom_range(511); lo = 0; hi = 0; end
               default: begin
                  dz = $urandom_range(511);
                  lo = $urandom_range(65535);
                  hi = $urandom_range(65535);
               end
            endcase
            load_settings(dz, lo, hi);
         end
         calm = (p == 3);
         if (p == 5) tstamp = 32'hFFFF_F000;
         phase_end = sent + PHASE_ITEMS;
         while (sent < phase_end) begin
            if ($urandom_range(39) == 0) drain_results();
            if ($urandom_range(9) < 8) begin
               // gesture: rest in the dead zone, push out, hold with timed samples
               repeat ($urandom_range(2)) begin
                  mag  = $urandom_range(int'(board.dz_level));
                  defl = $urandom_range(1) ? DEFL_W'(-mag) : DEFL_W'(mag);
                  tstamp += $urandom_range(50);
                  send_sample(defl, tstamp);
               end
               sgn = $urandom_range(1) ? 1 : -1;
               n   = $urandom_range(12, 3);
               for (int k = 0; k <= n; k++) begin
                  if (k == 0 || $urandom_range(3) == 0) begin
                     mag = $urandom_range(FULL_SCALE, int'(board.dz_level) + 1);
                     if ($urandom_range(7) == 0) sgn = -sgn;
                     if (mag == FULL_SCALE) sgn = -1;
                  end
                  if (k > 0) begin
                     dly = board.step_delay(mag);
                     case ($urandom_range(5))
                        0: ;
                        1: tstamp += dly - 1;
                        2: tstamp += dly;
                        3: tstamp += dly + $urandom_range(20);
                        4: tstamp += $urandom_range(dly);
                        default: tstamp += $urandom;
                     endcase
                  end else begin
                     tstamp += $urandom_range(50);
                  end
                  defl = DEFL_W'(sgn * mag);
                  send_sample(defl, tstamp);
               end
            end else begin
               defl = DEFL_W'($urandom);
               if ($urandom_range(1)) tstamp = $urandom;
               else tstamp += $urandom_range(300);
               send_sample(defl, tstamp);
            end
         end
      end

      drain_results();
      $display("Swept %0d samples over %0d register settings, reset values included.",
               board.samples, NUM_SETTINGS + 1);
      $display("Predicted %0d dead-zone exits and %0d position steps.",
               board.exits, board.steps);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/dssl_pkg.sv
rtl/dssl_req_if.sv
rtl/dssl_rsp_if.sv
rtl/dssl_csr_if.sv
rtl/dssl_ctrl.sv
rtl/dssl_dp.sv
rtl/deflection_speed_led_sweep.sv
tb/tb.sv
